// ===== hdl/apjs_pkg.sv =====
// Shared types and codes for the aging priority job scheduler.
package apjs_pkg;

    localparam int TAG_BITS = 8;
    localparam int LEN_BITS = 8;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED    = 2'd0,
        ST_REJECTED = 2'd1,
        ST_RAN      = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Flags carried along the scan chain.
    typedef struct packed {
        logic free_found;
        logic best_found;
    } t_scan_ctl;

    // Fields of the current best candidate carried along the chain.
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [LEN_BITS-1:0] len;
        logic [LEN_BITS-1:0] done;
    } t_slot_info;

    // Slot write command broadcast to all cells.
    typedef struct packed {
        logic                en;
        logic                used;
        logic [TAG_BITS-1:0] tag;
        logic [LEN_BITS-1:0] len;
        logic [LEN_BITS-1:0] done;
    } t_slot_wr;

endpackage

// ===== hdl/apjs_if.sv =====
// Valid/ready channel interfaces for job items and result items.
interface apjs_job_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] job_tag;
    logic [7:0] run_length;

    modport source(output valid, output cmd, output job_tag, output run_length, input ready);
    modport sink(input valid, input cmd, input job_tag, input run_length, output ready);
endinterface

interface apjs_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] ran_tag;
    logic       finished;

    modport source(output valid, output status, output ran_tag, output finished, input ready);
    modport sink(input valid, input status, input ran_tag, input finished, output ready);
endinterface

// ===== hdl/apjs_cell.sv =====
// One slot of the job table: holds a job and folds it into the passing scan.
module apjs_cell import apjs_pkg::*; #(
    parameter int PB  = 32,
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cv,
    input  t_scan_ctl        i_ctl,
    input  logic [PB-1:0]    i_max,
    input  logic [PB-1:0]    i_bprio,
    input  logic [IW-1:0]    i_bidx,
    input  logic [IW-1:0]    i_fidx,
    input  t_slot_info       i_binfo,
    output logic             o_cv,
    output t_scan_ctl        o_ctl,
    output logic [PB-1:0]    o_max,
    output logic [PB-1:0]    o_bprio,
    output logic [IW-1:0]    o_bidx,
    output logic [IW-1:0]    o_fidx,
    output t_slot_info       o_binfo,
    input  t_slot_wr         i_wr,
    input  logic [IW-1:0]    i_wr_idx,
    input  logic [PB-1:0]    i_wr_prio,
    output logic             o_used
);

    logic                r_used;
    logic [TAG_BITS-1:0] r_tag;
    logic [LEN_BITS-1:0] r_len;
    logic [LEN_BITS-1:0] r_done;
    logic [PB-1:0]       r_prio;

    logic                r_cv;
    t_scan_ctl           r_ctl;
    logic [PB-1:0]       r_max;
    logic [PB-1:0]       r_bprio;
    logic [IW-1:0]       r_bidx;
    logic [IW-1:0]       r_fidx;
    t_slot_info          r_binfo;

    logic w_take_best;
    logic w_new_max;
    logic w_take_free;
    logic w_hit;

    // Strict less-than keeps the lower slot on a tie.
    assign w_take_best = r_used && (!i_ctl.best_found || (r_prio < i_bprio));
    assign w_new_max   = r_used && (r_prio > i_max);
    assign w_take_free = !r_used && !i_ctl.free_found;
    assign w_hit       = i_wr.en && (i_wr_idx == IW'(IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_cv   <= 1'b0;
        end else begin
            r_cv <= i_cv;
            if (w_hit) begin
                r_used <= i_wr.used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_tag  <= i_wr.tag;
            r_len  <= i_wr.len;
            r_done <= i_wr.done;
            r_prio <= i_wr_prio;
        end
        if (i_cv) begin
            r_ctl.free_found <= i_ctl.free_found | w_take_free;
            r_ctl.best_found <= i_ctl.best_found | w_take_best;
            r_max            <= w_new_max ? r_prio : i_max;
            r_fidx           <= w_take_free ? IW'(IDX) : i_fidx;
            if (w_take_best) begin
                r_bprio       <= r_prio;
                r_bidx        <= IW'(IDX);
                r_binfo.tag   <= r_tag;
                r_binfo.len   <= r_len;
                r_binfo.done  <= r_done;
            end else begin
                r_bprio <= i_bprio;
                r_bidx  <= i_bidx;
                r_binfo <= i_binfo;
            end
        end
    end

    assign o_cv    = r_cv;
    assign o_ctl   = r_ctl;
    assign o_max   = r_max;
    assign o_bprio = r_bprio;
    assign o_bidx  = r_bidx;
    assign o_fidx  = r_fidx;
    assign o_binfo = r_binfo;
    assign o_used  = r_used;

endmodule

// ===== hdl/aging_priority_job_scheduler.sv =====
// Top level of the aging priority job scheduler: scan chain of slots and control.
//
// Use: items arrive on i_job (valid/ready). cmd 0 adds a job (job_tag,
// run_length) at priority one above the table's highest, or 1 when empty;
// cmd 1 is a time tick that runs the job with the smallest priority value
// (lowest slot on a tie), ages it by 2 and removes it once it has run its
// length. Each item gives exactly one result on o_res (status, ran_tag,
// finished).
// Timing: an accepted item starts a scan that moves one slot per cycle down
// the row of SLOTS cells, then the S_DONE state writes the chosen slot and
// loads the result register, one item at a time.
// Reset empties the table and the result register; slot contents other than
// the used flags are not cleared. When the receiver stalls, the result stays
// in its register and the next item may still be taken and scanned; its
// write-back waits until the held result transfers.
module aging_priority_job_scheduler import apjs_pkg::*; #(
    parameter int SLOTS         = 16,
    parameter int PRIORITY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apjs_job_if.sink    i_job,
    apjs_res_if.source  o_res
);

    localparam int PB = PRIORITY_BITS;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state              r_state, n_state;
    logic                r_cmd;
    logic [TAG_BITS-1:0] r_tag;
    logic [LEN_BITS-1:0] r_len;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [TAG_BITS-1:0] r_ran_tag, n_ran_tag;
    logic                r_finished, n_finished;

    logic                w_accept;
    logic                w_fire;
    t_slot_wr            w_wr;
    logic [IW-1:0]       w_wr_idx;
    logic [PB-1:0]       w_wr_prio;
    logic [SLOTS-1:0]    w_used;

    logic [PB:0]         w_add_sum;
    logic [PB:0]         w_tick_sum;
    logic [PB-1:0]       w_add_prio;
    logic [PB-1:0]       w_tick_prio;
    logic [LEN_BITS-1:0] w_done_n;
    logic [LEN_BITS-1:0] w_len_eff;
    logic                w_fin;

    logic                c_valid [SLOTS+1];
    t_scan_ctl           c_ctl   [SLOTS+1];
    logic [PB-1:0]       c_max   [SLOTS+1];
    logic [PB-1:0]       c_bprio [SLOTS+1];
    logic [IW-1:0]       c_bidx  [SLOTS+1];
    logic [IW-1:0]       c_fidx  [SLOTS+1];
    t_slot_info          c_binfo [SLOTS+1];

    assign i_job.ready = (r_state == S_IDLE);
    assign w_accept    = i_job.valid && i_job.ready;

    // Seed the chain at the head.
    assign c_valid[0] = w_accept;
    assign c_ctl[0]   = '0;
    assign c_max[0]   = '0;
    assign c_bprio[0] = '0;
    assign c_bidx[0]  = '0;
    assign c_fidx[0]  = '0;
    assign c_binfo[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        apjs_cell #(
            .PB  (PB),
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cv      (c_valid[g]),
            .i_ctl     (c_ctl[g]),
            .i_max     (c_max[g]),
            .i_bprio   (c_bprio[g]),
            .i_bidx    (c_bidx[g]),
            .i_fidx    (c_fidx[g]),
            .i_binfo   (c_binfo[g]),
            .o_cv      (c_valid[g+1]),
            .o_ctl     (c_ctl[g+1]),
            .o_max     (c_max[g+1]),
            .o_bprio   (c_bprio[g+1]),
            .o_bidx    (c_bidx[g+1]),
            .o_fidx    (c_fidx[g+1]),
            .o_binfo   (c_binfo[g+1]),
            .i_wr      (w_wr),
            .i_wr_idx  (w_wr_idx),
            .i_wr_prio (w_wr_prio),
            .o_used    (w_used[g])
        );
    end

    // Saturating priority updates: clamp to all ones on carry out.
    assign w_add_sum   = {1'b0, c_max[SLOTS]} + (PB+1)'(1);
    assign w_tick_sum  = {1'b0, c_bprio[SLOTS]} + (PB+1)'(2);
    assign w_add_prio  = w_add_sum[PB]  ? {PB{1'b1}} : w_add_sum[PB-1:0];
    assign w_tick_prio = w_tick_sum[PB] ? {PB{1'b1}} : w_tick_sum[PB-1:0];

    // A zero length behaves like a length of one.
    assign w_done_n  = c_binfo[SLOTS].done + LEN_BITS'(1);
    assign w_len_eff = (c_binfo[SLOTS].len == '0) ? LEN_BITS'(1) : c_binfo[SLOTS].len;
    assign w_fin     = (w_done_n >= w_len_eff);

    always_comb begin
        n_state    = r_state;
        w_fire     = 1'b0;
        w_wr       = '0;
        w_wr_idx   = '0;
        w_wr_prio  = '0;
        n_status   = ST_IDLE;
        n_ran_tag  = '0;
        n_finished = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (c_valid[SLOTS]) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    w_fire  = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_ADD) begin
                        if (c_ctl[SLOTS].free_found) begin
                            w_wr.en   = 1'b1;
                            w_wr.used = 1'b1;
                            w_wr.tag  = r_tag;
                            w_wr.len  = r_len;
                            w_wr.done = '0;
                            w_wr_idx  = c_fidx[SLOTS];
                            w_wr_prio = w_add_prio;
                            n_status  = ST_ADDED;
                        end else begin
                            n_status  = ST_REJECTED;
                        end
                    end else begin
                        if (c_ctl[SLOTS].best_found) begin
                            w_wr.en    = 1'b1;
                            w_wr.used  = !w_fin;
                            w_wr.tag   = c_binfo[SLOTS].tag;
                            w_wr.len   = c_binfo[SLOTS].len;
                            w_wr.done  = w_done_n;
                            w_wr_idx   = c_bidx[SLOTS];
                            w_wr_prio  = w_tick_prio;
                            n_status   = ST_RAN;
                            n_ran_tag  = c_binfo[SLOTS].tag;
                            n_finished = w_fin;
                        end else begin
                            n_status   = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_job.cmd;
            r_tag <= i_job.job_tag;
            r_len <= i_job.run_length;
        end
        if (w_fire) begin
            r_status   <= n_status;
            r_ran_tag  <= n_ran_tag;
            r_finished <= n_finished;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.status   = r_status;
    assign o_res.ran_tag  = r_ran_tag;
    assign o_res.finished = r_finished;

    // The scan reaches the tail once it has passed the registers of all SLOTS cells after a transfer in.
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##SLOTS c_valid[SLOTS])
        else $error("scan did not reach the last slot in time");

    // An add that found a free slot grows the table by exactly one.
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_cmd == CMD_ADD) && c_ctl[SLOTS].free_found)
        |=> ($countones(w_used) == $past($countones(w_used)) + 1))
        else $error("add did not occupy exactly one slot");

    // A rejected add only happens with every slot occupied.
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_cmd == CMD_ADD) && !c_ctl[SLOTS].free_found) |-> (&w_used))
        else $error("add rejected while a slot was free");

    // An idle tick only happens with the table empty.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_cmd == CMD_TICK) && !c_ctl[SLOTS].best_found) |-> (w_used == '0))
        else $error("idle tick while a job was waiting");

endmodule

// ===== tb/sv/aging_priority_job_scheduler_tb.sv =====
// Self-checking testbench for the aging priority job scheduler: directed, pressure and random runs.
`timescale 1ns / 1ps

module aging_priority_job_scheduler_tb;
    import apjs_pkg::*;

    localparam int SLOTS       = 16;
    localparam int PRIO_BITS   = 32;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES = 2 * (SLOTS + 2) + 8;
    localparam logic [PRIO_BITS-1:0] PRIO_MAX = '1;

    typedef struct packed {
        t_status             status;
        logic [TAG_BITS-1:0] ran_tag;
        logic                finished;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    apjs_job_if job_ch();
    apjs_res_if res_ch();

    aging_priority_job_scheduler #(
        .SLOTS         (SLOTS),
        .PRIORITY_BITS (PRIO_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the job table
    logic                 tbl_used [SLOTS] = '{default: 1'b0};
    logic [TAG_BITS-1:0]  tbl_tag  [SLOTS];
    logic [LEN_BITS-1:0]  tbl_len  [SLOTS];
    logic [LEN_BITS-1:0]  tbl_done [SLOTS];
    logic [PRIO_BITS-1:0] tbl_prio [SLOTS];

    t_outcome pending_outcomes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;

    int fail_count  = 0;
    int n_items     = 0;
    int n_added     = 0;
    int n_rejected  = 0;
    int n_ran       = 0;
    int n_finished  = 0;
    int n_idle      = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("aging_priority_job_scheduler verification failed");
        $finish;
    end

    function automatic logic [PRIO_BITS-1:0] prio_saturating_add(
        logic [PRIO_BITS-1:0] a, logic [PRIO_BITS-1:0] b);
        logic [PRIO_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[PRIO_BITS] ? PRIO_MAX : sum[PRIO_BITS-1:0];
    endfunction

    // Apply one item to the shadow table and return the result it must produce.
    function automatic t_outcome compute_outcome(logic cmd, logic [TAG_BITS-1:0] tag,
                                                 logic [LEN_BITS-1:0] len);
        t_outcome             res;
        logic [PRIO_BITS-1:0] top;
        int                   free_idx;
        int                   best;
        res.status   = ST_ADDED;
        res.ran_tag  = '0;
        res.finished = 1'b0;
        if (cmd == CMD_ADD) begin
            top = '0;
            free_idx = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_used[i]) begin
                    if (tbl_prio[i] > top) top = tbl_prio[i];
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (free_idx < 0) begin
                res.status = ST_REJECTED;
            end else begin
                tbl_used[free_idx] = 1'b1;
                tbl_tag[free_idx]  = tag;
                tbl_len[free_idx]  = len;
                tbl_done[free_idx] = '0;
                tbl_prio[free_idx] = prio_saturating_add(top, 1);
            end
        end else begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_used[i] && (best < 0 || tbl_prio[i] < tbl_prio[best])) best = i;
            end
            if (best < 0) begin
                res.status = ST_IDLE;
            end else begin
                tbl_done[best] = tbl_done[best] + 1'b1;
                tbl_prio[best] = prio_saturating_add(tbl_prio[best], 2);
                res.status  = ST_RAN;
                res.ran_tag = tbl_tag[best];
                // zero length counts as one unit
                if (tbl_done[best] >= tbl_len[best]) begin
                    tbl_used[best] = 1'b0;
                    res.finished   = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Call at a rising edge; returns at the edge where the item transfers.
    task automatic send_job(input logic cmd, input logic [TAG_BITS-1:0] tag,
                            input logic [LEN_BITS-1:0] len);
        t_outcome exp_item;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            job_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        job_ch.valid      <= 1'b1;
        job_ch.cmd        <= cmd;
        job_ch.job_tag    <= tag;
        job_ch.run_length <= len;
        do @(posedge i_clk); while (!job_ch.ready);
        exp_item = compute_outcome(cmd, tag, len);
        pending_outcomes = {pending_outcomes, exp_item};
        n_items++;
    endtask

    function automatic logic [LEN_BITS-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return '0;
        if (r < 85) return LEN_BITS'($urandom_range(6, 1));
        if (r < 97) return LEN_BITS'($urandom_range(40, 7));
        return LEN_BITS'($urandom_range(255, 200));
    endfunction

    // Result receiver: random stalls, plus one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                res_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome exp_out;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with nothing expected: status %0d ran_tag %0d finished %0d",
                       res_ch.status, res_ch.ran_tag, res_ch.finished);
                fail_count++;
            end else begin
                exp_out = pending_outcomes.pop_front();
                if (res_ch.status !== exp_out.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_out.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.ran_tag !== exp_out.ran_tag) begin
                    $error("ran_tag mismatch: expected %0d, actual %0d",
                           exp_out.ran_tag, res_ch.ran_tag);
                    fail_count++;
                end
                if (res_ch.finished !== exp_out.finished) begin
                    $error("finished mismatch: expected %0d, actual %0d",
                           exp_out.finished, res_ch.finished);
                    fail_count++;
                end
                case (exp_out.status)
                    ST_ADDED:    n_added++;
                    ST_REJECTED: n_rejected++;
                    ST_RAN: begin
                        n_ran++;
                        if (exp_out.finished) n_finished++;
                    end
                    default:     n_idle++;
                endcase
            end
        end
    end

    // Empty-table tick, field extremes, zero length, lowest free slot, full table
    task automatic test_directed();
        send_job(CMD_TICK, 8'h00, 8'h00);
        send_job(CMD_ADD, 8'h00, 8'd1);
        send_job(CMD_ADD, 8'hFF, 8'd0);
        send_job(CMD_ADD, 8'hA5, 8'd255);
        // first finishes at once, the zero-length job finishes on its only unit
        send_job(CMD_TICK, 8'hFF, 8'hFF);
        send_job(CMD_TICK, 8'h5A, 8'h01);
        send_job(CMD_TICK, 8'h00, 8'h00);
        // slot 0 and 1 are free again; fill the table up
        for (int i = 0; i < SLOTS - 1; i++)
            send_job(CMD_ADD, 8'($urandom_range(255)), (i % 2) ? 8'd255 : 8'd2);
        send_job(CMD_ADD, 8'h3C, 8'd1);
        send_job(CMD_TICK, 8'h00, 8'h00);
        send_job(CMD_TICK, 8'h00, 8'h00);
    endtask

    // Hold the result side off so the block backs up and stalls its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (int i = 0; i < 14; i++)
            send_job(($urandom_range(1) != 0) ? CMD_TICK : CMD_ADD,
                     8'($urandom_range(255)), pick_length());
    endtask

    task automatic test_random(input int n, input int add_pct,
                               input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n; i++)
            send_job(($urandom_range(99) < add_pct) ? CMD_ADD : CMD_TICK,
                     8'($urandom_range(255)), pick_length());
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        job_ch.valid      <= 1'b0;
        job_ch.cmd        <= CMD_ADD;
        job_ch.job_tag    <= '0;
        job_ch.run_length <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(190, 55, 0, 0);
        test_random(180, 70, 55, 0);
        test_random(180, 35, 0, 55);
        test_random(170, 50, 21, 21);

        job_ch.valid   <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending_outcomes.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d adds taken, %0d rejected on a full table, %0d idle ticks.",
                 n_items, n_added, n_rejected, n_idle);
        $display("Ticks ran %0d job units, %0d of them completing a job.", n_ran, n_finished);
        if (fail_count == 0) begin
            $display("aging_priority_job_scheduler verification clean");
        end else begin
            $display("aging_priority_job_scheduler verification failed");
        end
        $finish;
    end

endmodule
